FILE: rtl/pbs_pkg.sv
// Shared types, constants and saturation helper for the projectile bounce step block.
package pbs_pkg;

   localparam int MAX_BOXES_DEF = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 31;

   localparam logic [1:0] MODE_LAUNCH = 2'd0;
   localparam logic [1:0] MODE_LOAD   = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUSE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT  = 2'd2;

   localparam logic signed [32:0] GRAVITY_Q  = -33'sd1441792;
   localparam logic signed [31:0] RADIUS_Q   = 32'sd9830;
   localparam logic signed [17:0] FRICTION_Q = 18'sd52429;
   localparam logic [16:0]        ONE_Q      = 17'd65536;

   localparam logic [16:0] BOUNCE_RESET = 17'd32768;
   localparam logic [30:0] FUSE_RESET   = 31'd196608;
   localparam logic [4:0]  COUNT_RESET  = 5'd0;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         box_index;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               detonated;
      logic               in_flight;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] hi;
      logic [2:0][31:0] lo;
   } box_type;

   function automatic logic signed [31:0] sat_q(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/projectile_bounce_step_top.sv
// Top level of the projectile bounce step block: state registers, box memory and tick sequencer.
//
// Usage: one request word per item on req_* (mode 0 launch, 1 load box, 2 tick),
// one response word per item on rsp_* with the position after the item, the
// detonation flag and the live flag. Registers are written on csr_* (index 0
// bounce factor, 1 fuse time, 2 box count); the user must write them only while
// the block is idle, which the block itself does not enforce. Launch, load, unused
// mode and a tick while not live answer in the cycle after they are taken. A tick
// whose fuse runs out answers from the fuse state. Otherwise a tick does fuse,
// gravity, integration and floor work on one shared 33x18 multiplier, then walks
// the boxes: each box is read from a synchronous box memory, checked, and
// possibly damped with three more multiplies.
// One item is in work at a time; a new word is taken once the sequencer is
// idle and the response register is empty or being emptied.
// Reset (synchronous) clears position, velocity, fuse and live flag and sets the
// registers to their reset values; box memory contents stay undefined until loaded.
// A stalled response holds its word and blocks further requests.
module projectile_bounce_step_top #(
   parameter int MAX_BOXES = pbs_pkg::MAX_BOXES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pbs_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pbs_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pbs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pbs_pkg::*;

   localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int KW = $clog2(MAX_BOXES + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_FUSE, ST_GRAV, ST_PX, ST_PY, ST_PZ, ST_FLOOR,
      ST_FVY, ST_FVX, ST_FVZ, ST_BSTART, ST_BWAIT, ST_BEXP, ST_BSEL,
      ST_BM0, ST_BM1, ST_BM2, ST_BM3, ST_BNEXT, ST_DONE
   } state_type;

   typedef logic signed [31:0] q_type;

   state_type          state_ff;
   q_type              pos_ff [3];
   q_type              vel_ff [3];
   q_type              fuse_ff;
   logic               live_ff;
   logic [16:0]        bounce_ff;
   logic [30:0]        fuse_time_ff;
   logic [4:0]         count_ff;
   logic [15:0]        dt_ff;
   logic signed [32:0] mul_a_ff;
   logic signed [17:0] mul_b_ff;
   logic [KW-1:0]      k_ff;
   box_type            rd_ff;
   box_type            box_mem [MAX_BOXES];
   q_type              emin_ff [3];
   q_type              emax_ff [3];
   logic               inside_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_accept;
   logic [8:0]         idx_ext;
   logic [8:0]         n_lim;
   logic [8:0]         k_next;
   logic signed [50:0] prod;
   logic signed [51:0] prod_rnd;
   logic signed [51:0] prod_sh;
   q_type              mres;
   q_type              fuse_new;
   logic signed [17:0] dt_op;
   logic signed [17:0] bf_op;
   q_type              box_emin [3];
   q_type              box_emax [3];
   logic               box_in;
   logic signed [33:0] d_min [3];
   logic signed [33:0] d_max [3];
   logic               to_max_ax [3];
   logic signed [33:0] d_ax [3];
   logic [1:0]         axis;
   logic signed [33:0] best;
   logic               to_max;
   q_type              face;
   logic               reflect;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign idx_ext  = 9'(req_data.box_index);
   assign n_lim    = (9'(count_ff) > 9'(MAX_BOXES)) ? 9'(MAX_BOXES) : 9'(count_ff);
   assign k_next   = 9'(k_ff) + 9'd1;
   assign dt_op    = $signed({2'b00, dt_ff});
   assign bf_op    = $signed({1'b0, bounce_ff});

   assign prod     = mul_a_ff * mul_b_ff;
   assign prod_rnd = 52'(prod) + 52'sd32768;
   assign prod_sh  = prod_rnd >>> 16;
   assign mres     = sat_q(prod_sh[35:0]);
   assign fuse_new = sat_q(36'(fuse_ff) - 36'($signed({1'b0, dt_ff})));

   always_comb begin
      box_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         box_emin[i] = sat_q(36'($signed(rd_ff.lo[i])) - 36'(RADIUS_Q));
         box_emax[i] = sat_q(36'($signed(rd_ff.hi[i])) + 36'(RADIUS_Q));
         if ((pos_ff[i] < box_emin[i]) || (pos_ff[i] > box_emax[i])) begin
            box_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_min[i]     = 34'(pos_ff[i]) - 34'(emin_ff[i]);
         d_max[i]     = 34'(emax_ff[i]) - 34'(pos_ff[i]);
         to_max_ax[i] = !(d_min[i] < d_max[i]);
         d_ax[i]      = to_max_ax[i] ? d_max[i] : d_min[i];
      end
      axis   = 2'd0;
      best   = d_ax[0];
      to_max = to_max_ax[0];
      if (d_ax[1] < best) begin
         axis   = 2'd1;
         best   = d_ax[1];
         to_max = to_max_ax[1];
      end
      if (d_ax[2] < best) begin
         axis   = 2'd2;
         to_max = to_max_ax[2];
      end
      face    = to_max ? emax_ff[axis] : emin_ff[axis];
      reflect = to_max ? (vel_ff[axis] < 0) : (vel_ff[axis] > 0);
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_data.mode == MODE_LOAD) && (idx_ext < 9'(MAX_BOXES))) begin
         box_mem[idx_ext[IW-1:0]] <= '{
            hi: {req_data.second_z, req_data.second_y, req_data.second_x},
            lo: {req_data.first_z, req_data.first_y, req_data.first_x}};
      end
      rd_ff <= box_mem[k_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         live_ff      <= 1'b0;
         fuse_ff      <= '0;
         bounce_ff    <= BOUNCE_RESET;
         fuse_time_ff <= FUSE_RESET;
         count_ff     <= COUNT_RESET;
         k_ff         <= '0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BOUNCE: bounce_ff    <= (csr_data[16:0] > ONE_Q) ? ONE_Q : csr_data[16:0];
               CSR_FUSE:   fuse_time_ff <= csr_data;
               CSR_COUNT:  count_ff     <= csr_data[4:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  case (req_data.mode)
                     MODE_LAUNCH: begin
                        pos_ff[0] <= req_data.first_x;
                        pos_ff[1] <= req_data.first_y;
                        pos_ff[2] <= req_data.first_z;
                        vel_ff[0] <= req_data.second_x;
                        vel_ff[1] <= req_data.second_y;
                        vel_ff[2] <= req_data.second_z;
                        fuse_ff   <= $signed({1'b0, fuse_time_ff});
                        live_ff   <= 1'b1;
                        rsp_valid_ff          <= 1'b1;
                        rsp_data_ff.pos_x     <= req_data.first_x;
                        rsp_data_ff.pos_y     <= req_data.first_y;
                        rsp_data_ff.pos_z     <= req_data.first_z;
                        rsp_data_ff.detonated <= 1'b0;
                        rsp_data_ff.in_flight <= 1'b1;
                     end
                     MODE_TICK: begin
                        if (live_ff) begin
                           rsp_valid_ff <= 1'b0;
                           dt_ff        <= req_data.time_step;
                           state_ff     <= ST_FUSE;
                        end else begin
                           rsp_valid_ff          <= 1'b1;
                           rsp_data_ff.pos_x     <= pos_ff[0];
                           rsp_data_ff.pos_y     <= pos_ff[1];
                           rsp_data_ff.pos_z     <= pos_ff[2];
                           rsp_data_ff.detonated <= 1'b0;
                           rsp_data_ff.in_flight <= live_ff;
                        end
                     end
                     default: begin
                        rsp_valid_ff          <= 1'b1;
                        rsp_data_ff.pos_x     <= pos_ff[0];
                        rsp_data_ff.pos_y     <= pos_ff[1];
                        rsp_data_ff.pos_z     <= pos_ff[2];
                        rsp_data_ff.detonated <= 1'b0;
                        rsp_data_ff.in_flight <= live_ff;
                     end
                  endcase
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_FUSE: begin
               fuse_ff <= fuse_new;
               if (fuse_new <= 0) begin
                  live_ff               <= 1'b0;
                  rsp_valid_ff          <= 1'b1;
                  rsp_data_ff.pos_x     <= pos_ff[0];
                  rsp_data_ff.pos_y     <= pos_ff[1];
                  rsp_data_ff.pos_z     <= pos_ff[2];
                  rsp_data_ff.detonated <= 1'b1;
                  rsp_data_ff.in_flight <= 1'b0;
                  state_ff              <= ST_IDLE;
               end else begin
                  mul_a_ff <= GRAVITY_Q;
                  mul_b_ff <= dt_op;
                  state_ff <= ST_GRAV;
               end
            end
            ST_GRAV: begin
               vel_ff[1] <= sat_q(36'(vel_ff[1]) + 36'(mres));
               mul_a_ff  <= 33'(vel_ff[0]);
               state_ff  <= ST_PX;
            end
            ST_PX: begin
               pos_ff[0] <= sat_q(36'(pos_ff[0]) + 36'(mres));
               mul_a_ff  <= 33'(vel_ff[1]);
               state_ff  <= ST_PY;
            end
            ST_PY: begin
               pos_ff[1] <= sat_q(36'(pos_ff[1]) + 36'(mres));
               mul_a_ff  <= 33'(vel_ff[2]);
               state_ff  <= ST_PZ;
            end
            ST_PZ: begin
               pos_ff[2] <= sat_q(36'(pos_ff[2]) + 36'(mres));
               state_ff  <= ST_FLOOR;
            end
            ST_FLOOR: begin
               if (pos_ff[1] < RADIUS_Q) begin
                  pos_ff[1] <= RADIUS_Q;
                  if (vel_ff[1] < 0) begin
                     mul_a_ff <= -33'(vel_ff[1]);
                     mul_b_ff <= bf_op;
                     state_ff <= ST_FVY;
                  end else begin
                     mul_a_ff <= 33'(vel_ff[0]);
                     mul_b_ff <= FRICTION_Q;
                     state_ff <= ST_FVX;
                  end
               end else begin
                  state_ff <= ST_BSTART;
               end
            end
            ST_FVY: begin
               vel_ff[1] <= mres;
               mul_a_ff  <= 33'(vel_ff[0]);
               mul_b_ff  <= FRICTION_Q;
               state_ff  <= ST_FVX;
            end
            ST_FVX: begin
               vel_ff[0] <= mres;
               mul_a_ff  <= 33'(vel_ff[2]);
               state_ff  <= ST_FVZ;
            end
            ST_FVZ: begin
               vel_ff[2] <= mres;
               state_ff  <= ST_BSTART;
            end
            ST_BSTART: begin
               k_ff     <= '0;
               state_ff <= (n_lim == 9'd0) ? ST_DONE : ST_BWAIT;
            end
            ST_BWAIT: begin
               state_ff <= ST_BEXP;
            end
            ST_BEXP: begin
               inside_ff <= box_in;
               for (int i = 0; i < 3; i++) begin
                  emin_ff[i] <= box_emin[i];
                  emax_ff[i] <= box_emax[i];
               end
               state_ff <= ST_BSEL;
            end
            ST_BSEL: begin
               if (inside_ff) begin
                  pos_ff[axis] <= face;
                  if (reflect) begin
                     vel_ff[axis] <= sat_q(-36'(vel_ff[axis]));
                     state_ff     <= ST_BM0;
                  end else begin
                     state_ff <= ST_BNEXT;
                  end
               end else begin
                  state_ff <= ST_BNEXT;
               end
            end
            ST_BM0: begin
               mul_a_ff <= 33'(vel_ff[0]);
               mul_b_ff <= bf_op;
               state_ff <= ST_BM1;
            end
            ST_BM1: begin
               vel_ff[0] <= mres;
               mul_a_ff  <= 33'(vel_ff[1]);
               state_ff  <= ST_BM2;
            end
            ST_BM2: begin
               vel_ff[1] <= mres;
               mul_a_ff  <= 33'(vel_ff[2]);
               state_ff  <= ST_BM3;
            end
            ST_BM3: begin
               vel_ff[2] <= mres;
               state_ff  <= ST_BNEXT;
            end
            ST_BNEXT: begin
               k_ff     <= k_next[KW-1:0];
               state_ff <= (k_next >= n_lim) ? ST_DONE : ST_BWAIT;
            end
            ST_DONE: begin
               rsp_valid_ff          <= 1'b1;
               rsp_data_ff.pos_x     <= pos_ff[0];
               rsp_data_ff.pos_y     <= pos_ff[1];
               rsp_data_ff.pos_z     <= pos_ff[2];
               rsp_data_ff.detonated <= 1'b0;
               rsp_data_ff.in_flight <= live_ff;
               state_ff              <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
